/* hdl/alsa_pkg.sv */
// Shared types and constants for the adjacent line difference scorer.
`default_nettype none

package alsa_pkg;

   localparam int MAX_LINE_LENGTH = 4096;
   localparam int COL_W           = $clog2(MAX_LINE_LENGTH);
   localparam int LEN_W           = 13;
   localparam int LINE_W          = 12;
   localparam int SUM_W           = 20;
   localparam int PIX_W           = 8;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;

   localparam logic [LEN_W-1:0]  LEN_RESET   = LEN_W'(4096);
   localparam logic [LINE_W-1:0] FIRST_RESET = LINE_W'(0);
   localparam logic [LINE_W-1:0] LAST_RESET  = LINE_W'(4095);
   localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_LINE_LENGTH);
   localparam logic [LINE_W-1:0] LINE_MAX_POS = {LINE_W{1'b1}};

   typedef enum logic [1:0] {
      REG_LINE_LENGTH = 2'd0,
      REG_FIRST_LINE  = 2'd1,
      REG_LAST_LINE   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]  line_length;
      logic [LINE_W-1:0] first_line;
      logic [LINE_W-1:0] last_line;
   } cfg_type;

endpackage

`default_nettype wire

/* hdl/adjacent_line_sad_argmax.sv */
// Top level: scores each line by its absolute difference to the next line.
//
// Pixels enter on the req_ channel in raster order, one item per pixel, with
// req_end_of_image high on the last pixel of the image. For each line j in
// [first_line, last_line) the block sums |line j+1 - line j| over the line
// and keeps the first line with the largest sum. Set line_length, first_line
// and last_line over the csr_ port between images.
// One rsp_ item leaves per image: best_line, best_sum and found (0 when all
// scored sums were zero, with line and sum then 0).
// Throughput is one pixel per cycle while req_stall is low: the line store is a
// single-port memory read and written once per pixel. rsp_valid rises once the
// end-of-image item has passed the input register and then the result register.
// A stalled result is held in the result register while pixels keep flowing;
// req_stall rises only when the next end-of-image item reaches the input
// stage while the previous result is still stalled.
// Reset clears the counters, the best-line tracker and the pipeline and loads
// the register defaults; the line store is not cleared and needs no pass,
// since the first line of an image is never scored.
`default_nettype none

module adjacent_line_sad_argmax
   import alsa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [PIX_W-1:0]      req_pixel,
   input  wire logic                  req_end_of_image,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [LINE_W-1:0]     rsp_best_line,
   output logic      [SUM_W-1:0]      rsp_best_sum,
   output logic                       rsp_found,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type cfg;

   alsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------- accept stage: position counters ----------------
   logic              accept;
   logic [LEN_W-1:0]  len_eff;
   logic              end_line;
   logic [LINE_W-1:0] line_j;
   logic              scoring;

   logic [COL_W-1:0]  col_ff,      col_in;
   logic [LINE_W-1:0] line_pos_ff, line_pos_in;
   logic              overflow_ff, overflow_in;

   assign accept = req_valid && !req_stall;

   always_comb begin
      if (cfg.line_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (cfg.line_length > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = cfg.line_length;
      end
   end

   assign end_line = (LEN_W'(col_ff) + LEN_W'(1)) >= len_eff;
   assign line_j   = line_pos_ff - LINE_W'(1);
   assign scoring  = (line_pos_ff != '0) && !overflow_ff &&
                     (line_j >= cfg.first_line) && (line_j < cfg.last_line);

   always_comb begin
      col_in      = col_ff;
      line_pos_in = line_pos_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         if (req_end_of_image) begin
            col_in      = '0;
            line_pos_in = '0;
            overflow_in = 1'b0;
         end else if (end_line) begin
            col_in = '0;
            if (line_pos_ff == LINE_MAX_POS) begin
               overflow_in = 1'b1;
            end else begin
               line_pos_in = line_pos_ff + LINE_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         line_pos_ff <= '0;
         overflow_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         line_pos_ff <= line_pos_in;
         overflow_ff <= overflow_in;
      end
   end

   logic [PIX_W-1:0] prev_pixel;

   alsa_line_mem u_line_mem (
      .clock      (clock),
      .enable     (accept),
      .address    (col_ff),
      .write_data (req_pixel),
      .read_data  (prev_pixel)
   );

   // ---------------- input register ----------------
   logic              s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]  s1_pixel_ff;
   logic              s1_scoring_ff;
   logic              s1_end_ff;
   logic [LINE_W-1:0] s1_line_ff;
   logic              s1_eoi_ff;
   logic              s1_advance;
   logic              s1_blocked;
   logic              rsp_valid_ff, rsp_valid_in;

   assign s1_blocked = s1_eoi_ff && rsp_valid_ff && rsp_stall;
   assign s1_advance = s1_valid_ff && !s1_blocked;
   assign req_stall  = s1_valid_ff && s1_blocked;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff   <= req_pixel;
         s1_scoring_ff <= scoring;
         s1_end_ff     <= end_line;
         s1_line_ff    <= line_j;
         s1_eoi_ff     <= req_end_of_image;
      end
   end

   // ---------------- score stage ----------------
   logic [SUM_W-1:0]  run_sum_ff,  run_sum_in;
   logic [SUM_W-1:0]  best_sum_ff, best_sum_in;
   logic [LINE_W-1:0] best_line_ff, best_line_in;
   logic              best_valid_ff, best_valid_in;

   logic [PIX_W-1:0]  diff;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_new;
   logic              better;
   logic [SUM_W-1:0]  next_best_sum;
   logic [LINE_W-1:0] next_best_line;
   logic              next_best_valid;

   assign diff = (s1_pixel_ff >= prev_pixel) ? (s1_pixel_ff - prev_pixel)
                                             : (prev_pixel - s1_pixel_ff);
   assign sum_wide = {1'b0, run_sum_ff} + (SUM_W+1)'(diff);

   // Saturate at the top of the sum range.
   always_comb begin
      if (!s1_scoring_ff) begin
         sum_new = run_sum_ff;
      end else if (sum_wide[SUM_W]) begin
         sum_new = '1;
      end else begin
         sum_new = sum_wide[SUM_W-1:0];
      end
   end

   // Strictly larger only, so the first maximum wins.
   assign better          = s1_scoring_ff && s1_end_ff && (sum_new > best_sum_ff);
   assign next_best_sum   = better ? sum_new : best_sum_ff;
   assign next_best_line  = better ? s1_line_ff : best_line_ff;
   assign next_best_valid = best_valid_ff || better;

   always_comb begin
      run_sum_in    = run_sum_ff;
      best_sum_in   = best_sum_ff;
      best_line_in  = best_line_ff;
      best_valid_in = best_valid_ff;
      if (s1_advance) begin
         if (s1_eoi_ff) begin
            run_sum_in    = '0;
            best_sum_in   = '0;
            best_line_in  = '0;
            best_valid_in = 1'b0;
         end else begin
            run_sum_in    = s1_end_ff ? '0 : sum_new;
            best_sum_in   = next_best_sum;
            best_line_in  = next_best_line;
            best_valid_in = next_best_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_sum_ff    <= '0;
         best_sum_ff   <= '0;
         best_line_ff  <= '0;
         best_valid_ff <= 1'b0;
      end else begin
         run_sum_ff    <= run_sum_in;
         best_sum_ff   <= best_sum_in;
         best_line_ff  <= best_line_in;
         best_valid_ff <= best_valid_in;
      end
   end

   // ---------------- result register ----------------
   logic [LINE_W-1:0] rsp_line_ff;
   logic [SUM_W-1:0]  rsp_sum_ff;
   logic              rsp_found_ff;
   logic              load_result;

   assign load_result = s1_advance && s1_eoi_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         rsp_line_ff  <= next_best_line;
         rsp_sum_ff   <= next_best_sum;
         rsp_found_ff <= next_best_valid;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_best_line = rsp_line_ff;
   assign rsp_best_sum  = rsp_sum_ff;
   assign rsp_found     = rsp_found_ff;

   // ---------------- checks ----------------
   a_empty_result_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_best_sum == '0) && (rsp_best_line == '0))
      else $error("result without a found line carries a non-zero line or sum");

   a_found_has_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_best_sum != '0)
      else $error("found line with a zero sum");

   a_image_end_clears: assert property (@(posedge clock) disable iff (reset)
      load_result |=> (run_sum_ff == '0) && !best_valid_ff && (best_sum_ff == '0))
      else $error("tracker not cleared after end of image");

   a_stall_only_on_held_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_eoi_ff && rsp_valid_ff)
      else $error("input stalled without a held result ahead of an image end");

   a_best_valid_sum: assert property (@(posedge clock) disable iff (reset)
      best_valid_ff == (best_sum_ff != '0))
      else $error("best valid flag disagrees with best sum");

endmodule

`default_nettype wire

/* hdl/alsa_csr.sv */
// Configuration registers behind the APB-style port.
`default_nettype none

module alsa_csr
   import alsa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] index;
   logic       write;

   assign index      = csr_paddr[3:2];
   assign write      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            REG_LINE_LENGTH: cfg_in.line_length = csr_pwdata[LEN_W-1:0];
            REG_FIRST_LINE:  cfg_in.first_line  = csr_pwdata[LINE_W-1:0];
            REG_LAST_LINE:   cfg_in.last_line   = csr_pwdata[LINE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_LINE_LENGTH: csr_prdata = CSR_DATA_W'(cfg_ff.line_length);
         REG_FIRST_LINE:  csr_prdata = CSR_DATA_W'(cfg_ff.first_line);
         REG_LAST_LINE:   csr_prdata = CSR_DATA_W'(cfg_ff.last_line);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_length <= LEN_RESET;
         cfg_ff.first_line  <= FIRST_RESET;
         cfg_ff.last_line   <= LAST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/alsa_line_mem.sv */
// Previous-line store: one read-first port, read data registered.
`default_nettype none

module alsa_line_mem
   import alsa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [COL_W-1:0] address,
   input  wire logic [PIX_W-1:0] write_data,
   output logic      [PIX_W-1:0] read_data
);

   logic [PIX_W-1:0] mem [MAX_LINE_LENGTH];
   logic [PIX_W-1:0] read_data_ff;

   assign read_data = read_data_ff;

   // Read the old pixel and overwrite it with the new one in the same edge.
   always_ff @(posedge clock) begin
      if (enable) begin
         read_data_ff <= mem[address];
         mem[address] <= write_data;
      end
   end

endmodule

`default_nettype wire

/* tb/sv/adjacent_line_sad_argmax_checker.sv */
// Checker: predicts the best-line result of each image and compares it with the rsp_ channel.
module adjacent_line_sad_argmax_checker
   import alsa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [PIX_W-1:0]      req_pixel,
   input  wire logic                  req_end_of_image,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [LINE_W-1:0]     rsp_best_line,
   input  wire logic [SUM_W-1:0]      rsp_best_sum,
   input  wire logic                  rsp_found,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic                  csr_pready,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                         failures,
   output int                         outstanding,
   output int                         results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUM_LIMIT = (1 << SUM_W) - 1;

   typedef struct {
      logic [LINE_W-1:0] line;
      logic [SUM_W-1:0]  sum;
      logic              found;
   } image_best_type;

   image_best_type predicted_best_q[$];

   logic [LEN_W-1:0]  len_reg   = LEN_RESET;
   logic [LINE_W-1:0] first_reg = FIRST_RESET;
   logic [LINE_W-1:0] last_reg  = LAST_RESET;

   logic [PIX_W-1:0]  prior_line [MAX_LINE_LENGTH];
   int                col_pos;
   logic [LINE_W-1:0] line_pos;
   logic              lines_exhausted;
   logic [SUM_W-1:0]  line_sad;
   logic [SUM_W-1:0]  best_sum;
   logic [LINE_W-1:0] best_line;
   logic              best_seen;
   int                fail_count = 0;
   int                seen_count = 0;

   function automatic void start_image();
      col_pos         = 0;
      line_pos        = '0;
      lines_exhausted = 1'b0;
      line_sad        = '0;
      best_sum        = '0;
      best_line       = '0;
      best_seen       = 1'b0;
   endfunction

   function automatic void score_pixel(input logic [PIX_W-1:0] pix, input logic last_pixel);
      int                eff_len;
      logic [LINE_W-1:0] j;
      logic              scored;
      int                diff;
      int                sum_next;
      image_best_type    res;
      eff_len = (len_reg == '0) ? 1 : ((len_reg > LEN_MAX) ? MAX_LINE_LENGTH : int'(len_reg));
      j = line_pos - 1'b1;
      scored = (line_pos != '0) && !lines_exhausted && (j >= first_reg) && (j < last_reg);
      if (scored) begin
         diff = int'(pix) - int'(prior_line[col_pos]);
         if (diff < 0) diff = -diff;
         sum_next = int'(line_sad) + diff;
         line_sad = (sum_next > SUM_LIMIT) ? SUM_W'(SUM_LIMIT) : SUM_W'(sum_next);
      end
      prior_line[col_pos] = pix;
      if (col_pos + 1 >= eff_len) begin
         // strictly larger only, so the first maximum is kept
         if (scored && line_sad > best_sum) begin
            best_sum  = line_sad;
            best_line = j;
            best_seen = 1'b1;
         end
         line_sad = '0;
         col_pos  = 0;
         if (line_pos == LINE_MAX_POS) lines_exhausted = 1'b1;
         else line_pos = line_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1;
      end
      if (last_pixel) begin
         res.found = best_seen;
         res.line  = best_seen ? best_line : '0;
         res.sum   = best_seen ? best_sum : '0;
         predicted_best_q.push_back(res);
         start_image();
      end
   endfunction

   always @(posedge clock) begin
      image_best_type exp_best;
      if (reset) begin
         len_reg   = LEN_RESET;
         first_reg = FIRST_RESET;
         last_reg  = LAST_RESET;
         predicted_best_q.delete();
         start_image();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_count++;
            if (predicted_best_q.size() == 0) begin
               $display("%0t: result with none pending: line %0d sum %0d found %0b",
                        $time, rsp_best_line, rsp_best_sum, rsp_found);
               fail_count++;
            end else begin
               exp_best = predicted_best_q.pop_front();
               if (rsp_found !== exp_best.found) begin
                  $display("%0t: found expected %0b actual %0b",
                           $time, exp_best.found, rsp_found);
                  fail_count++;
               end
               if (rsp_best_line !== exp_best.line) begin
                  $display("%0t: best_line expected %0d actual %0d",
                           $time, exp_best.line, rsp_best_line);
                  fail_count++;
               end
               if (rsp_best_sum !== exp_best.sum) begin
                  $display("%0t: best_sum expected %0d actual %0d",
                           $time, exp_best.sum, rsp_best_sum);
                  fail_count++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_LINE_LENGTH: len_reg   = csr_pwdata[LEN_W-1:0];
               REG_FIRST_LINE:  first_reg = csr_pwdata[LINE_W-1:0];
               REG_LAST_LINE:   last_reg  = csr_pwdata[LINE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) score_pixel(req_pixel, req_end_of_image);
      end
      failures     <= fail_count;
      outstanding  <= predicted_best_q.size();
      results_seen <= seen_count;
   end
endmodule

/* tb/sv/adjacent_line_sad_argmax_tb.sv */
// Testbench top: drives images and register writes into the scorer and reports the verdict.
module adjacent_line_sad_argmax_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import alsa_pkg::*;

   typedef enum int {
      STYLE_RANDOM,
      STYLE_ALTERNATE,
      STYLE_FLAT,
      STYLE_EXTREME,
      STYLE_STRIPE
   } image_style_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel        = '0;
   logic                  req_end_of_image = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [LINE_W-1:0]     rsp_best_line;
   logic [SUM_W-1:0]      rsp_best_sum;
   logic                  rsp_found;
   logic                  csr_psel         = 1'b0;
   logic                  csr_penable      = 1'b0;
   logic                  csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int failures;
   int outstanding;
   int results_seen;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_sent     = 0;
   int images_sent    = 0;
   int line_len_now   = MAX_LINE_LENGTH;

   logic [PIX_W-1:0] line_a [MAX_LINE_LENGTH];
   logic [PIX_W-1:0] line_b [MAX_LINE_LENGTH];

   adjacent_line_sad_argmax dut (.*);

   adjacent_line_sad_argmax_checker checker_i (
      .failures(failures),
      .outstanding(outstanding),
      .results_seen(results_seen),
      .*
   );

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d results outstanding", outstanding);
      $display("FAIL adjacent_line_sad_argmax");
      $finish;
   end

   task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic last_pixel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel        <= pix;
      req_end_of_image <= last_pixel;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // hold the sender until every result is back, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input int unsigned value);
      int unsigned field_w;
      field_w = (idx == REG_LINE_LENGTH) ? LEN_W : LINE_W;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      // junk above the field must be dropped
      csr_pwdata  <= value | ($urandom() << field_w);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_window(input int len_code, input int first, input int last);
      settle();
      write_csr(REG_LINE_LENGTH, len_code);
      write_csr(REG_FIRST_LINE, first);
      write_csr(REG_LAST_LINE, last);
      line_len_now = (len_code == 0) ? 1 : ((len_code > MAX_LINE_LENGTH) ? MAX_LINE_LENGTH
                                                                        : len_code);
   endtask

   // cut drops pixels from the end, leaving a partial last line
   task automatic send_image(input int lines, input image_style_type style, input int cut);
      int total;
      int line;
      int col;
      logic [PIX_W-1:0] pix;
      total = line_len_now * lines - cut;
      if (total < 1) total = 1;
      for (int c = 0; c < line_len_now; c++) begin
         line_a[c] = (style == STYLE_STRIPE) ? 8'h00 : PIX_W'($urandom());
         line_b[c] = (style == STYLE_STRIPE) ? 8'hFF : PIX_W'($urandom());
      end
      for (int n = 0; n < total; n++) begin
         line = n / line_len_now;
         col  = n % line_len_now;
         case (style)
            STYLE_RANDOM:  pix = PIX_W'($urandom());
            STYLE_FLAT:    pix = line_a[0];
            STYLE_EXTREME: pix = $urandom_range(1) ? 8'hFF : 8'h00;
            default:       pix = line[0] ? line_b[col] : line_a[col];
         endcase
         push_pixel(pix, n == total - 1);
      end
      images_sent++;
   endtask

   task automatic random_image();
      int lines;
      int len_pick;
      int first;
      int last;
      int cut;
      image_style_type style;
      lines = $urandom_range(1, 10);
      style = image_style_type'($urandom_range(0, 4));
      if ($urandom_range(3) == 0) begin
         len_pick = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         first    = $urandom_range(0, lines);
         last     = ($urandom_range(5) == 0) ? $urandom_range(0, first)
                                             : $urandom_range(first, lines + 2);
         if (len_pick == 1 && $urandom_range(1)) len_pick = 0;
         set_window(len_pick, first, last);
      end
      cut = ($urandom_range(4) == 0) ? $urandom_range(1, line_len_now * lines) : 0;
      send_image(lines, style, cut);
   endtask

   initial begin
      int mark;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one pixel at reset defaults: nothing scored
      push_pixel(8'hA5, 1'b1);
      images_sent++;

      // length code 0 acts as 1; equal scores keep the first line
      set_window(0, 0, 4095);
      push_pixel(8'h00, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h00, 1'b1);
      images_sent++;

      // narrow window, partial last line discarded
      set_window(3, 1, 3);
      send_image(4, STYLE_RANDOM, 2);

      // empty window with the top first_line
      set_window(3, 4095, 0);
      send_image(2, STYLE_EXTREME, 0);

      // zero differences everywhere
      set_window(2, 0, 4095);
      send_image(3, STYLE_FLAT, 0);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct  = (ph == 0) ? 7 : ((ph == 1) ? 45 : 0);
         recv_stall_pct = (ph == 0) ? 45 : ((ph == 1) ? 7 : 0);
         mark = items_sent;
         while (items_sent - mark < 170) random_image();
      end

      // largest sum: full-length lines of 0 against 255
      set_window(4096, 0, 4095);
      send_image(2, STYLE_STRIPE, 0);

      // oversized length code clamps to the maximum
      set_window(8191, 0, 1);
      send_image(2, STYLE_RANDOM, 0);

      // run past the last line index with the window at its top
      set_window(1, 4090, 4095);
      send_image(4100, STYLE_RANDOM, 0);

      settle();
      repeat (8) @(posedge clock);
      $display("Covered %0d pixel items in %0d images, %0d results checked", items_sent,
               images_sent, results_seen);
      $display("Lengths from 1 to the maximum, empty and top windows, partial lines, ties");
      if (failures == 0) begin
         $display("PASS adjacent_line_sad_argmax");
      end else begin
         $display("FAIL adjacent_line_sad_argmax");
      end
      $finish;
   end
endmodule
